@@ sv/rld_pkg.sv @@
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the run-length letter decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NEXT  = 2'd3
  } cmd_t;

  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

  localparam int unsigned COUNT_W = 32;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] letter;
    logic       has_next;
    logic       table_full;
  } out_t;

  typedef struct packed {
    logic [7:0]         letter;
    logic [COUNT_W-1:0] count;
  } run_t;

endpackage

@@ sv/run_length_letter_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// run_length_letter_decoder_unit
// Loads letter/count runs from compressed text and hands them out one letter
// per read command.
// ----------------------------------------------------------------------------
// out_valid is registered and rises in the cycle after start; one command per cycle.
// busy is always low; the receiver cannot stall, each result shows for 1 cycle.
// The run at the read position sits in a head register; the table's registered
// read port keeps the following run ready, so a run change needs no wait.
// Reset (synchronous, rst_n low) empties the table and restores pending
// letter '0' with count 0; table contents are left as they are.
module run_length_letter_decoder_unit #(
  parameter int unsigned MAX_RUNS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rld_pkg::in_t   in_data,
  output logic           out_valid,
  output rld_pkg::out_t  out_data
);

  localparam int unsigned AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RUNS);
  localparam int unsigned NW = rld_pkg::COUNT_W;

  logic [CW-1:0]  stored_r, stored_nxt;
  logic [CW-1:0]  rd_pos_r, rd_pos_nxt;
  logic [NW-1:0]  remain_r, remain_nxt;
  logic [NW-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [7:0]     pend_let_r, pend_let_nxt;
  logic           out_valid_r;
  rld_pkg::out_t  out_data_r, out_nxt;
  rld_pkg::run_t  head_r, head_nxt;

  logic           accept;
  logic           is_digit, is_letter;
  logic           flush, wr_en, full;
  logic           have_run, advance;
  logic [NW-1:0]  cur_cnt, rem_dec;
  logic [NW+3:0]  times_ten;
  rld_pkg::run_t  wr_data, rd_data;
  logic [CW-1:0]  rd_next_pos;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_digit  = in_data.in_byte inside {[rld_pkg::CHAR_ZERO:rld_pkg::CHAR_NINE]};
  assign is_letter = in_data.in_byte inside {[rld_pkg::CHAR_UPPER_A:rld_pkg::CHAR_UPPER_Z],
                                             [rld_pkg::CHAR_LOWER_A:rld_pkg::CHAR_LOWER_Z]};

  // count*10 + digit as shift-add, saturated to 32 bits
  assign times_ten = {1'b0, pend_cnt_r, 3'b000} + {3'b000, pend_cnt_r, 1'b0}
                   + (NW+4)'(in_data.in_byte - rld_pkg::CHAR_ZERO);

  assign flush = accept && (pend_cnt_r != '0)
              && (((in_data.command == rld_pkg::CMD_LOAD) && is_letter)
                  || (in_data.command == rld_pkg::CMD_END));
  assign wr_en = flush && (stored_r < MAX_CNT);
  assign full  = flush && !wr_en;

  assign wr_data.letter = pend_let_r;
  assign wr_data.count  = pend_cnt_r;

  assign have_run = rd_pos_r < stored_r;
  assign cur_cnt  = (remain_r == '0) ? head_r.count : remain_r;
  assign rem_dec  = cur_cnt - NW'(1);
  assign advance  = accept && (in_data.command == rld_pkg::CMD_NEXT) && have_run
                 && (rem_dec == '0);

  always_comb begin
    stored_nxt   = stored_r;
    rd_pos_nxt   = rd_pos_r;
    remain_nxt   = remain_r;
    pend_cnt_nxt = pend_cnt_r;
    pend_let_nxt = pend_let_r;
    out_nxt      = '0;
    if (accept) begin
      case (in_data.command)
        rld_pkg::CMD_CLEAR: begin
          stored_nxt   = '0;
          rd_pos_nxt   = '0;
          remain_nxt   = '0;
          pend_cnt_nxt = '0;
          pend_let_nxt = rld_pkg::CHAR_ZERO;
        end
        rld_pkg::CMD_LOAD: begin
          if (is_digit) begin
            pend_cnt_nxt = (times_ten[NW+3:NW] != '0) ? '1 : times_ten[NW-1:0];
          end else if (is_letter) begin
            pend_cnt_nxt = '0;
            pend_let_nxt = in_data.in_byte;
          end
        end
        rld_pkg::CMD_END: begin
          pend_cnt_nxt = '0;
          pend_let_nxt = rld_pkg::CHAR_ZERO;
        end
        default: begin
          if (have_run) begin
            out_nxt.letter = head_r.letter;
            remain_nxt     = rem_dec;
            if (rem_dec == '0) begin
              rd_pos_nxt = rd_pos_r + CW'(1);
            end
          end else begin
            out_nxt.letter = rld_pkg::CHAR_SPACE;
          end
        end
      endcase
      if (wr_en) begin
        stored_nxt = stored_r + CW'(1);
      end
    end
    out_nxt.has_next   = rd_pos_nxt < stored_nxt;
    out_nxt.table_full = full;
  end

  // head holds the run at the read position; table read port holds the next
  always_comb begin
    head_nxt = head_r;
    if (wr_en && (stored_r == rd_pos_r)) begin
      head_nxt = wr_data;
    end else if (advance) begin
      head_nxt = rd_data;
    end
  end

  assign rd_next_pos = rd_pos_nxt + CW'(1);

  rld_run_table #(
    .DEPTH (MAX_RUNS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stored_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_next_pos[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r    <= '0;
      rd_pos_r    <= '0;
      remain_r    <= '0;
      pend_cnt_r  <= '0;
      pend_let_r  <= rld_pkg::CHAR_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      stored_r    <= stored_nxt;
      rd_pos_r    <= rd_pos_nxt;
      remain_r    <= remain_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      pend_let_r  <= pend_let_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- checks
  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= MAX_CNT)
    else $error("run count beyond table depth");

  a_rd_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pos_r <= stored_r)
    else $error("read position past stored runs");

  a_remain_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (remain_r != '0) |-> (rd_pos_r < stored_r))
    else $error("repeats pending with no run left");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command produced no result");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (stored_r == MAX_CNT))
    else $error("run dropped below table depth");

endmodule

@@ sv/rld_run_table.sv @@
// ----------------------------------------------------------------------------
// rld_run_table
// Run storage: one write port, one registered read port, write-first on a
// same-address collision so the read data always reflects the latest write.
// ----------------------------------------------------------------------------
module rld_run_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  rld_pkg::run_t       wr_data,
  input  logic [AW-1:0]       rd_addr,
  output rld_pkg::run_t       rd_data
);

  rld_pkg::run_t mem [DEPTH];
  rld_pkg::run_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
